// ----- rtl/sgsa_pkg.sv -----
// Shared types and constants for the SiLU / GELU / SwiGLU activation unit.
// Used by sgsa_exp, sgsa_div and silu_gelu_swiglu_activation.
`default_nettype none
package sgsa_pkg;

    localparam int XW = 16;

    localparam logic [1:0] MODE_GELU   = 2'd1;
    localparam logic [1:0] MODE_SWIGLU = 2'd2;
    localparam logic       REG_MODE    = 1'b0;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [29:0] ZMAX_Q24  = 30'h2000_0000;
    localparam logic [30:0] VMAX_Q24  = 31'h4000_0000;
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [24:0] C2_Q24    = 25'd26772563;
    localparam logic [15:0] A_Q20     = 16'd46887;
    localparam logic [12:0] LN2_RECIP = 13'd5909;
    localparam logic [15:0] UNIT_Q11  = 16'd2048;
    localparam logic [62:0] HALF_Q41  = 63'h100_0000_0000;

    // ceil(2^34 / k) for k = 9 down to 1, one entry per series step.
    localparam logic [34:0] HORNER_RECIP [9] = '{
        35'd1908874354, 35'd2147483648, 35'd2454267027,
        35'd2863311531, 35'd3435973837, 35'd4294967296,
        35'd5726623062, 35'd8589934592, 35'd17179869184
    };

    typedef struct packed {
        logic [XW-1:0] xm;
        logic [XW-1:0] um;
        logic          xneg;
        logic          uneg;
        logic          last;
    } side_t;

endpackage
`default_nettype wire

// ----- rtl/sgsa_exp.sv -----
// Pipelined exp(-t) in Q.30: range reduction by ln2 and a nine-step series.
// Depends on sgsa_pkg.
`default_nettype none
module sgsa_exp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [29:0]     t,
    input  sgsa_pkg::side_t in_side,
    output logic            out_valid,
    output logic [30:0]     e,
    output sgsa_pkg::side_t out_side
);
    import sgsa_pkg::*;

    typedef struct packed {
        side_t       side;
        logic [29:0] rr;
        logic [5:0]  n;
    } hctx_t;

    logic        r1_valid_reg, r2_valid_reg, r3_valid_reg, e_valid_reg;
    logic [42:0] r1_prod_reg;
    logic [29:0] r1_t_reg;
    side_t       r1_side_reg, r2_side_reg, e_side_reg;
    logic [5:0]  r2_n_reg;
    logic [24:0] r2_r_reg;
    hctx_t       r3_ctx_reg;
    logic [30:0] e_reg;

    logic [6:0]  n0;
    logic [30:0] nl;
    logic [30:0] r0;

    logic        ha_valid_reg [9];
    logic [60:0] ha_prod_reg  [9];
    hctx_t       ha_ctx_reg   [9];
    logic        hb_valid_reg [9];
    logic [64:0] hb_prod_reg  [9];
    hctx_t       hb_ctx_reg   [9];
    logic        hc_valid_reg [9];
    logic [30:0] hc_p_reg     [9];
    hctx_t       hc_ctx_reg   [9];

    logic        h_valid_in [9];
    logic [30:0] h_p_in     [9];
    hctx_t       h_ctx_in   [9];

    assign n0 = r1_prod_reg[42:36];
    assign nl = 31'(n0) * 31'(LN2_Q24);
    assign r0 = 31'(r1_t_reg) - nl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= in_valid;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            e_valid_reg  <= hc_valid_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_prod_reg <= 43'(t) * 43'(LN2_RECIP);
            r1_t_reg    <= t;
            r1_side_reg <= in_side;
            r2_n_reg    <= n0[5:0];
            r2_r_reg    <= r0[24:0];
            r2_side_reg <= r1_side_reg;
            r3_ctx_reg.side <= r2_side_reg;
            if (r2_r_reg >= 25'(LN2_Q24))
            begin
                r3_ctx_reg.n  <= r2_n_reg + 6'd1;
                r3_ctx_reg.rr <= {24'(r2_r_reg - 25'(LN2_Q24)), 6'b0};
            end
            else
            begin
                r3_ctx_reg.n  <= r2_n_reg;
                r3_ctx_reg.rr <= {r2_r_reg[23:0], 6'b0};
            end
            e_reg      <= hc_p_reg[8] >> hc_ctx_reg[8].n;
            e_side_reg <= hc_ctx_reg[8].side;
        end
    end

    for (genvar s = 0; s < 9; s++)
    begin : g_step
        if (s == 0)
        begin : g_first
            assign h_valid_in[s] = r3_valid_reg;
            assign h_p_in[s]     = ONE_Q30;
            assign h_ctx_in[s]   = r3_ctx_reg;
        end
        else
        begin : g_rest
            assign h_valid_in[s] = hc_valid_reg[s-1];
            assign h_p_in[s]     = hc_p_reg[s-1];
            assign h_ctx_in[s]   = hc_ctx_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ha_valid_reg[s] <= 1'b0;
                hb_valid_reg[s] <= 1'b0;
                hc_valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                ha_valid_reg[s] <= h_valid_in[s];
                hb_valid_reg[s] <= ha_valid_reg[s];
                hc_valid_reg[s] <= hb_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ha_prod_reg[s] <= 61'(h_ctx_in[s].rr) * 61'(h_p_in[s]);
                ha_ctx_reg[s]  <= h_ctx_in[s];
                hb_prod_reg[s] <= 65'(ha_prod_reg[s][59:30]) * 65'(HORNER_RECIP[s]);
                hb_ctx_reg[s]  <= ha_ctx_reg[s];
                hc_p_reg[s]    <= ONE_Q30 - {1'b0, hb_prod_reg[s][63:34]};
                hc_ctx_reg[s]  <= hb_ctx_reg[s];
            end
        end
    end

    assign out_valid = e_valid_reg;
    assign e         = e_reg;
    assign out_side  = e_side_reg;

endmodule
`default_nettype wire

// ----- rtl/sgsa_div.sv -----
// Pipelined rounded reciprocal: floor((2^60 + d/2) / d) with d = 2^30 + e,
// one quotient bit per stage. Depends on sgsa_pkg.
`default_nettype none
module sgsa_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [30:0]     e,
    input  sgsa_pkg::side_t in_side,
    output logic            out_valid,
    output logic [30:0]     s,
    output sgsa_pkg::side_t out_side
);
    import sgsa_pkg::*;

    localparam logic [30:0] REM_INIT = 31'h2000_0000;

    logic        d0_valid_reg;
    logic [31:0] d0_d_reg;
    side_t       d0_side_reg;

    logic        dv_valid_reg [31];
    logic [31:0] dv_d_reg     [31];
    logic [30:0] dv_rem_reg   [31];
    logic [30:0] dv_q_reg     [31];
    side_t       dv_side_reg  [31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_d_reg    <= 32'(ONE_Q30) + 32'(e);
            d0_side_reg <= in_side;
        end
    end

    for (genvar j = 0; j < 31; j++)
    begin : g_bit
        logic        v_in;
        logic [31:0] d_in;
        logic [30:0] rem_in;
        logic [30:0] q_in;
        side_t       side_in;
        logic [31:0] rem_sh;
        logic        take;

        if (j == 0)
        begin : g_first
            assign v_in    = d0_valid_reg;
            assign d_in    = d0_d_reg;
            assign rem_in  = REM_INIT;
            assign q_in    = '0;
            assign side_in = d0_side_reg;
        end
        else
        begin : g_rest
            assign v_in    = dv_valid_reg[j-1];
            assign d_in    = dv_d_reg[j-1];
            assign rem_in  = dv_rem_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign side_in = dv_side_reg[j-1];
        end

        assign rem_sh = {rem_in, d_in[31-j]};
        assign take   = rem_sh >= d_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_d_reg[j]    <= d_in;
                dv_rem_reg[j]  <= take ? 31'(rem_sh - d_in) : rem_sh[30:0];
                dv_q_reg[j]    <= {q_in[29:0], take};
                dv_side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = dv_valid_reg[30];
    assign s         = dv_q_reg[30];
    assign out_side  = dv_side_reg[30];

endmodule
`default_nettype wire

// ----- rtl/silu_gelu_swiglu_activation.sv -----
// Throughput: one item per cycle; a stall at the output freezes every stage.
// The pipeline depth is set by the nine-step exp series (three stages a step) and the
// one-bit-per-stage reciprocal divider.
// Reset clears all valid bits and sets mode to SiLU.
// Depends on sgsa_pkg, sgsa_exp and sgsa_div.
`default_nettype none
module silu_gelu_swiglu_activation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // x_value [15:0], up_value [31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // y_value [31:0]
    output logic        m_axis_tlast
);
    import sgsa_pkg::*;

    logic [1:0]  mode_reg;
    logic        adv;

    logic [XW-1:0] x_in, u_in;
    side_t       side_in;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic        v8_reg, v9_reg, ov_reg;
    side_t       sd1_reg, sd2_reg, sd3_reg, sd4_reg, sd5_reg, sd6_reg, sd7_reg;
    side_t       sd8_reg, sd9_reg;
    logic [31:0] sq_reg;
    logic [47:0] cube_reg;
    logic [54:0] g_reg;
    logic [30:0] v_reg;
    logic [55:0] w_reg;
    logic [29:0] t_reg;
    logic [46:0] sx_reg;
    logic [62:0] prod_reg;
    logic [31:0] y_reg;
    logic        last_reg;

    logic [35:0] v_sum;
    logic [31:0] t_sel;
    logic        ex_valid, dv_valid;
    logic [30:0] ex_e, dv_s, sig;
    side_t       ex_side, dv_side;
    logic [15:0] u_sel;
    logic [21:0] mag;
    logic        neg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {30'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE)
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    assign adv           = !ov_reg || m_axis_tready;
    assign s_axis_tready = adv;

    assign x_in         = s_axis_tdata[XW-1:0];
    assign u_in         = s_axis_tdata[2*XW-1:XW];
    assign side_in.xneg = x_in[XW-1];
    assign side_in.uneg = u_in[XW-1];
    assign side_in.xm   = x_in[XW-1] ? (~x_in + 1'b1) : x_in;
    assign side_in.um   = u_in[XW-1] ? (~u_in + 1'b1) : u_in;
    assign side_in.last = s_axis_tlast;

    assign v_sum = 36'({sd4_reg.xm, 13'b0}) + 36'(g_reg[54:20]);
    assign t_sel = (mode_reg == MODE_GELU) ? w_reg[55:24] : 32'({sd6_reg.xm, 13'b0});
    assign sig   = dv_side.xneg ? 31'(ONE_Q30 - dv_s) : dv_s;
    assign u_sel = (mode_reg == MODE_SWIGLU) ? sd8_reg.um : UNIT_Q11;
    assign mag   = prod_reg[62:41];
    assign neg   = ((mode_reg == MODE_SWIGLU) ? (sd9_reg.xneg ^ sd9_reg.uneg)
                                              : sd9_reg.xneg) && (mag != 22'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= dv_valid;
            v9_reg <= v8_reg;
            ov_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd1_reg  <= side_in;
            sd2_reg  <= sd1_reg;
            sq_reg   <= 32'(sd1_reg.xm) * 32'(sd1_reg.xm);
            sd3_reg  <= sd2_reg;
            cube_reg <= 48'(sq_reg) * 48'(sd2_reg.xm);
            sd4_reg  <= sd3_reg;
            g_reg    <= 55'(cube_reg[47:9]) * 55'(A_Q20);
            sd5_reg  <= sd4_reg;
            v_reg    <= (v_sum > 36'(VMAX_Q24)) ? VMAX_Q24 : v_sum[30:0];
            sd6_reg  <= sd5_reg;
            w_reg    <= 56'(v_reg) * 56'(C2_Q24);
            sd7_reg  <= sd6_reg;
            t_reg    <= (t_sel > 32'(ZMAX_Q24)) ? ZMAX_Q24 : t_sel[29:0];
            sd8_reg  <= dv_side;
            sx_reg   <= 47'(dv_side.xm) * 47'(sig);
            sd9_reg  <= sd8_reg;
            prod_reg <= 63'(sx_reg) * 63'(u_sel) + HALF_Q41;
            y_reg    <= neg ? (32'b0 - 32'(mag)) : 32'(mag);
            last_reg <= sd9_reg.last;
        end
    end

    sgsa_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .t         (t_reg),
        .in_side   (sd7_reg),
        .out_valid (ex_valid),
        .e         (ex_e),
        .out_side  (ex_side)
    );

    sgsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ex_valid),
        .e         (ex_e),
        .in_side   (ex_side),
        .out_valid (dv_valid),
        .s         (dv_s),
        .out_side  (dv_side)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = y_reg;
    assign m_axis_tlast  = last_reg;

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> t_reg <= ZMAX_Q24)
        else $error("exp argument above clamp");

    a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid |-> ex_e <= ONE_Q30)
        else $error("exp term above one");

    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |-> (dv_s <= ONE_Q30 && dv_s >= 31'h2000_0000))
        else $error("sigmoid out of range");

endmodule
`default_nettype wire

// ----- tb/tb_silu_gelu_swiglu_activation.sv -----
// Testbench for silu_gelu_swiglu_activation: directed items, then random streams in every mode.
// Results are checked field by field against an integer predictor written here.
// Depends on sgsa_pkg and the RTL of the activation unit.
`timescale 1ns / 1ps
module tb_silu_gelu_swiglu_activation;
    import sgsa_pkg::*;

    localparam logic [1:0] MODE_SILU = 2'd0;
    localparam logic [1:0] MODE_RSVD = 2'd3;
    localparam int REG_SPARE = 1;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] y;
        logic        last;
    } act_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] x;
        logic [15:0] up;
        logic        last;
        bit          typed;
        logic [31:0] y;
    } act_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [1:0]  act_mode = MODE_SILU;
    act_result_t pending_q[$];
    logic [31:0] typed_q[$];
    bit          typed_flag_q[$];
    int          errors = 0;
    bit          calm = 0;
    int          hold_left = 0;

    silu_gelu_swiglu_activation dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] exp_neg(input logic [63:0] t);
        logic [63:0] n, r, p;
        n = t / 64'd11629080;
        r = (t - n * 64'd11629080) << 6;
        p = 64'd1 << 30;
        for (int k = 9; k >= 1; k--)
            p = (64'd1 << 30) - ((r * p) >> 30) / k;
        return (n >= 63) ? 64'd0 : (p >> n);
    endfunction

    function automatic logic [63:0] sigmoid_pos(input logic [63:0] t);
        logic [63:0] d;
        if (t > (64'd1 << 29))
            t = 64'd1 << 29;
        d = (64'd1 << 30) + exp_neg(t);
        return ((64'd1 << 60) + d / 2) / d;
    endfunction

    function automatic logic [63:0] gelu_arg(input logic [63:0] m);
        logic [63:0] cube, v;
        if (m > (64'd1 << 17))
            m = 64'd1 << 17;
        cube = m * m * m;
        v = (m << 13) + (((cube >> 9) * 64'd46887) >> 20);
        if (v > (64'd1 << 30))
            v = 64'd1 << 30;
        return (v * 64'd26772563) >> 24;
    endfunction

    function automatic logic [31:0] activation(input logic [1:0] md, input logic [15:0] x,
                                               input logic [15:0] up);
        logic        xneg, uneg, neg;
        logic [63:0] xm, um, t, sig, u, mag;
        xneg = x[15];
        uneg = up[15];
        xm = xneg ? 64'(-x) & 64'hFFFF : 64'(x);
        um = uneg ? 64'(-up) & 64'hFFFF : 64'(up);
        if (xm == 0 && xneg)
            xm = 64'h8000;
        if (um == 0 && uneg)
            um = 64'h8000;
        if (md == MODE_GELU)
            t = gelu_arg(xm);
        else
        begin
            t = xm << 13;
            if (t > (64'd1 << 29))
                t = 64'd1 << 29;
        end
        sig = sigmoid_pos(t);
        if (xneg)
            sig = (64'd1 << 30) - sig;
        if (md == MODE_SWIGLU)
        begin
            u = um;
            neg = xneg ^ uneg;
        end
        else
        begin
            u = 64'd2048;
            neg = xneg;
        end
        mag = (xm * sig * u + (64'd1 << 40)) >> 41;
        if (mag == 0)
            neg = 1'b0;
        if (neg)
        begin
            if (mag > (64'd1 << 31))
                mag = 64'd1 << 31;
            return 32'(~mag + 1);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return 32'(mag);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_q.push_back({activation(act_mode, s_axis_tdata[15:0], s_axis_tdata[31:16]),
                                 s_axis_tlast});
    end

    always @(posedge clk)
    begin
        act_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch($sformatf("unexpected item y=%h", m_axis_tdata));
            else
            begin
                want = pending_q.pop_front();
                if (typed_flag_q.size() > 0)
                begin
                    if (typed_flag_q.pop_front() && typed_q[0] != m_axis_tdata)
                        report_mismatch($sformatf("typed y got %h want %h",
                                                  m_axis_tdata, typed_q[0]));
                    void'(typed_q.pop_front());
                end
                if (m_axis_tdata !== want.y)
                    report_mismatch($sformatf("y got %h want %h", m_axis_tdata, want.y));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last got %b want %b", m_axis_tlast, want.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end

    task automatic reg_write(input int index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(index * 4);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready && index == int'(REG_MODE))
            act_mode = value[1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic [15:0] x, input logic [15:0] up, input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {up, x};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(64)) - 32);
            3, 4: return 16'(int'($urandom_range(12288)) - 6144);
            default: return 16'($urandom);
        endcase
    endfunction

    act_row_t rows[] = '{
        '{MODE_SILU,   16'h0000, 16'h1234, 1'b0, 1, 32'h0},
        '{MODE_SILU,   16'h7FFF, 16'h0000, 1'b1, 0, 32'h0},
        '{MODE_SILU,   16'h8000, 16'hFFFF, 1'b0, 0, 32'h0},
        '{MODE_SILU,   16'h0800, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_SILU,   16'hF800, 16'h0000, 1'b1, 0, 32'h0},
        '{MODE_SILU,   16'h0001, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_SILU,   16'hFFFF, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_GELU,   16'h0000, 16'hFFFF, 1'b1, 1, 32'h0},
        '{MODE_GELU,   16'h7FFF, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_GELU,   16'h8000, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_GELU,   16'h0800, 16'h0000, 1'b1, 0, 32'h0},
        '{MODE_GELU,   16'hF800, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_GELU,   16'hFFF0, 16'h0000, 1'b0, 0, 32'h0},
        '{MODE_SWIGLU, 16'h7FFF, 16'h0000, 1'b0, 1, 32'h0},
        '{MODE_SWIGLU, 16'h0000, 16'h7FFF, 1'b1, 1, 32'h0},
        '{MODE_SWIGLU, 16'h7FFF, 16'h7FFF, 1'b0, 0, 32'h0},
        '{MODE_SWIGLU, 16'h7FFF, 16'h8000, 1'b0, 0, 32'h0},
        '{MODE_SWIGLU, 16'h8000, 16'h8000, 1'b1, 0, 32'h0},
        '{MODE_SWIGLU, 16'h8000, 16'h7FFF, 1'b0, 0, 32'h0},
        '{MODE_SWIGLU, 16'h0800, 16'hF800, 1'b0, 0, 32'h0},
        '{MODE_RSVD,   16'h0800, 16'h5555, 1'b1, 0, 32'h0},
        '{MODE_RSVD,   16'h8000, 16'hAAAA, 1'b0, 0, 32'h0},
        '{MODE_RSVD,   16'h0000, 16'h0000, 1'b0, 1, 32'h0}
    };

    logic [1:0] phase_modes[] = '{MODE_SILU, MODE_GELU, MODE_SWIGLU, MODE_RSVD,
                                  MODE_SWIGLU, MODE_GELU, MODE_SILU};

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        reg_write(REG_SPARE, 32'h0000_0002);
        foreach (rows[i])
        begin
            if (rows[i].mode != act_mode)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                drain();
                reg_write(int'(REG_MODE), {30'h3FFF_FFFF, rows[i].mode});
            end
            typed_flag_q.push_back(rows[i].typed);
            typed_q.push_back(rows[i].y);
            send_item(rows[i].x, rows[i].up, rows[i].last);
        end
        foreach (phase_modes[ph])
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            drain();
            reg_write(int'(REG_MODE), {30'($urandom_range(1 << 29)), phase_modes[ph]});
            calm = (ph == 2);
            if (ph == 1)
                hold_left = HOLD_CYCLES;
            repeat (205)
                send_item(pick_value(), pick_value(), 1'($urandom_range(7) == 0));
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        calm = 0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/sgsa_pkg.sv
rtl/sgsa_exp.sv
rtl/sgsa_div.sv
rtl/silu_gelu_swiglu_activation.sv
tb/tb_silu_gelu_swiglu_activation.sv
